// ----- src/uart_register_block_with_rx_queue_unit_defines.svh -----
// assertion macros used by the rtl file
`ifndef UART_REGISTER_BLOCK_WITH_RX_QUEUE_UNIT_DEFINES_SVH
`define UART_REGISTER_BLOCK_WITH_RX_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define UARTRQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define UARTRQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UARTRQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define UARTRQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- src/uartrq_pkg.sv -----
`default_nettype none

package uartrq_pkg;

    // receive queue geometry
    localparam int RX_QUEUE_DEPTH = 16;
    localparam int RX_PTR_W       = $clog2(RX_QUEUE_DEPTH);
    localparam int RX_CNT_W       = $clog2(RX_QUEUE_DEPTH + 1);
    localparam int RX_SUM_W       = RX_PTR_W + 1;

    localparam logic [RX_CNT_W-1:0] RX_CNT_FULL = RX_CNT_W'(RX_QUEUE_DEPTH);
    localparam logic [RX_SUM_W-1:0] RX_SUM_WRAP = RX_SUM_W'(RX_QUEUE_DEPTH);

    // stream payload widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_RX    = 2'd2,
        REQ_BAD   = 2'd3
    } req_type_t;

    // register map
    localparam logic [7:0] ADDR_DATA    = 8'h00;
    localparam logic [7:0] ADDR_STATUS  = 8'h04;
    localparam logic [7:0] ADDR_CONTROL = 8'h08;
    localparam logic [7:0] ADDR_SCALER  = 8'h0C;

    // status values
    localparam logic [2:0] ST_TX_IDLE    = 3'h6;
    localparam logic [2:0] ST_DATA_HELD  = 3'h1;
    localparam int         ST_DATA_READY = 0;

    // control bit positions
    localparam int CT_RX_ENABLE = 0;
    localparam int CT_TX_ENABLE = 1;
    localparam int CT_RX_IRQ    = 2;
    localparam int CT_TX_IRQ    = 3;

    localparam logic [31:0] CONTROL_RESET = 32'h7;

    localparam logic RESP_OK  = 1'b0;
    localparam logic RESP_ERR = 1'b1;

endpackage

`default_nettype wire

// ----- src/uart_register_block_with_rx_queue_unit.sv -----
// channel   direction  payload
// --------  ---------  ----------------------------------------------------------
// s_axis    in         tuser req_type, tdata reg_addr/write_value/rx_char, tlast batch end
// m_axis    out        tdata read_value/tx_char/irq_pulse/rx_dropped, tuser resp_code/tx_valid
//
// a transaction waits in the input register until the output register is free; then the
// register update and its result land in the output register together and m_tvalid rises
// a new transaction is accepted every cycle while m_tready is high; the state update for
// one transaction is complete before the next leaves the input register, so back-to-back
// items are exact
// m_tready low holds the output register and backs up into the input register
// aresetn is synchronous and active low; the receive queue store has no reset
`default_nettype none
`include "uart_register_block_with_rx_queue_unit_defines.svh"

module uart_register_block_with_rx_queue_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: [7:0] reg_addr, [39:8] write_value, [47:40] rx_char
    input  wire logic [uartrq_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: [1:0] req_type
    input  wire logic [uartrq_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire logic                            s_tlast,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // m_tdata: [31:0] read_value, [39:32] tx_char, [40] irq_pulse, [41] rx_dropped,
    // [47:42] zero
    output logic [uartrq_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: [0] resp_code, [1] tx_valid
    output logic [uartrq_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready
);

    import uartrq_pkg::*;

    // input register
    logic        in_valid_reg;
    req_type_t   in_type_reg;
    logic [7:0]  in_addr_reg;
    logic [31:0] in_wval_reg;
    logic [7:0]  in_rxc_reg;
    logic        in_last_reg;

    // output register
    logic        out_valid_reg;
    logic [31:0] rd_reg;
    logic        resp_reg;
    logic        txv_reg;
    logic [7:0]  txc_reg;
    logic        irq_reg;
    logic        drop_reg;

    // register file
    logic [7:0]  holding_reg,  holding_next;
    logic [2:0]  status_reg,   status_next;
    logic [31:0] control_reg,  control_next;
    logic [31:0] scaler_reg,   scaler_next;
    logic [RX_CNT_W-1:0] rx_count_reg, rx_count_next;
    logic [RX_PTR_W-1:0] rx_head_reg,  rx_head_next;
    logic [7:0]  rx_queue_mem [RX_QUEUE_DEPTH];

    // per-transaction results
    logic        advance;
    logic [31:0] rd_c;
    logic        resp_c;
    logic        txv_c;
    logic [7:0]  txc_c;
    logic        irq_c;
    logic        drop_c;
    logic        push_c;

    // queue pointer arithmetic
    logic [RX_SUM_W-1:0] head_plus;
    logic [RX_PTR_W-1:0] head_inc;
    logic [RX_SUM_W-1:0] tail_sum;
    logic [RX_PTR_W-1:0] tail_idx;
    logic [7:0]          head_byte_reg;
    logic                queue_full;
    logic                queue_empty;

    // stage handshake: the input register moves whenever the output register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign head_plus = RX_SUM_W'(rx_head_reg) + RX_SUM_W'(1);
    assign head_inc  = (head_plus >= RX_SUM_WRAP) ? '0 : head_plus[RX_PTR_W-1:0];
    assign tail_sum  = RX_SUM_W'(rx_head_reg) + RX_SUM_W'(rx_count_reg);
    assign tail_idx  = (tail_sum >= RX_SUM_WRAP) ? RX_PTR_W'(tail_sum - RX_SUM_WRAP)
                                                 : tail_sum[RX_PTR_W-1:0];
    assign queue_full  = (rx_count_reg >= RX_CNT_FULL);
    assign queue_empty = (rx_count_reg == '0);

    always_comb begin
        holding_next  = holding_reg;
        status_next   = status_reg;
        control_next  = control_reg;
        scaler_next   = scaler_reg;
        rx_count_next = rx_count_reg;
        rx_head_next  = rx_head_reg;
        rd_c          = '0;
        resp_c        = RESP_OK;
        txv_c         = 1'b0;
        txc_c         = '0;
        irq_c         = 1'b0;
        drop_c        = 1'b0;
        push_c        = 1'b0;

        unique case (in_type_reg)
            REQ_READ: begin
                unique case (in_addr_reg)
                    ADDR_DATA: begin
                        rd_c = {24'h0, holding_reg};
                        if (!queue_empty) begin
                            // next queued byte moves up into the data register
                            holding_next  = head_byte_reg;
                            rx_head_next  = head_inc;
                            rx_count_next = rx_count_reg - RX_CNT_W'(1);
                            irq_c         = control_reg[CT_RX_IRQ];
                        end else begin
                            status_next                = status_reg | ST_TX_IDLE;
                            status_next[ST_DATA_READY] = 1'b0;
                            holding_next               = '0;
                        end
                    end
                    ADDR_STATUS:  rd_c = {29'h0, status_reg};
                    ADDR_CONTROL: rd_c = control_reg;
                    ADDR_SCALER:  rd_c = scaler_reg;
                    default:      resp_c = RESP_ERR;
                endcase
            end
            REQ_WRITE: begin
                unique case (in_addr_reg)
                    ADDR_DATA: begin
                        if (control_reg[CT_TX_ENABLE]) begin
                            // byte goes straight out, transmitter back to idle
                            txv_c        = 1'b1;
                            txc_c        = in_wval_reg[7:0];
                            status_next  = ST_TX_IDLE;
                            holding_next = '0;
                            irq_c        = control_reg[CT_TX_IRQ];
                        end else begin
                            holding_next = in_wval_reg[7:0];
                            status_next  = ST_DATA_HELD;
                        end
                    end
                    ADDR_STATUS:  ;
                    ADDR_CONTROL: control_next = in_wval_reg;
                    ADDR_SCALER:  scaler_next  = in_wval_reg;
                    default:      resp_c = RESP_ERR;
                endcase
            end
            REQ_RX: begin
                if (control_reg[CT_RX_ENABLE]) begin
                    push_c = !queue_full;
                    drop_c = queue_full;
                    if (in_last_reg) begin
                        // on an empty queue the byte just pushed is the head
                        holding_next  = queue_empty ? in_rxc_reg : head_byte_reg;
                        rx_head_next  = head_inc;
                        rx_count_next = queue_full ? (rx_count_reg - RX_CNT_W'(1))
                                                   : rx_count_reg;
                        status_next   = ST_DATA_HELD;
                        irq_c         = control_reg[CT_RX_IRQ];
                    end else if (push_c) begin
                        rx_count_next = rx_count_reg + RX_CNT_W'(1);
                    end
                end
            end
            REQ_BAD: resp_c = RESP_ERR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            holding_reg   <= '0;
            status_reg    <= ST_TX_IDLE;
            control_reg   <= CONTROL_RESET;
            scaler_reg    <= '0;
            rx_count_reg  <= '0;
            rx_head_reg   <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                holding_reg   <= holding_next;
                status_reg    <= status_next;
                control_reg   <= control_next;
                scaler_reg    <= scaler_next;
                rx_count_reg  <= rx_count_next;
                rx_head_reg   <= rx_head_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_type_reg <= req_type_t'(s_tuser[1:0]);
            in_addr_reg <= s_tdata[7:0];
            in_wval_reg <= s_tdata[39:8];
            in_rxc_reg  <= s_tdata[47:40];
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            rd_reg   <= rd_c;
            resp_reg <= resp_c;
            txv_reg  <= txv_c;
            txc_reg  <= txc_c;
            irq_reg  <= irq_c;
            drop_reg <= drop_c;
        end
    end

    // receive queue store; the byte at the new head is read into a register,
    // taken straight from the input when it is the byte written this cycle
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (push_c) begin
                rx_queue_mem[tail_idx] <= in_rxc_reg;
            end
            if (push_c && (tail_idx == rx_head_next)) begin
                head_byte_reg <= in_rxc_reg;
            end else begin
                head_byte_reg <= rx_queue_mem[rx_head_next];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'h0, drop_reg, irq_reg, txc_reg, rd_reg};
    assign m_tuser  = {txv_reg, resp_reg};

    `UARTRQ_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, rx_count_reg <= RX_CNT_FULL,
        "rx count beyond queue depth")
    `UARTRQ_ASSERT_NEXT(a_tx_idle, aclk, aresetn, advance && txv_c,
        (status_reg == ST_TX_IDLE) && (holding_reg == '0), "transmit did not return to idle")
    `UARTRQ_ASSERT_NOW(a_irq_enabled, aclk, aresetn, advance && irq_c,
        control_reg[CT_RX_IRQ] || control_reg[CT_TX_IRQ], "interrupt raised while disabled")
    `UARTRQ_ASSERT_NOW(a_result_excl, aclk, aresetn, out_valid_reg && txv_reg,
        (resp_reg == RESP_OK) && (rd_reg == '0) && !drop_reg,
        "transmit result carries read or error data")
    `UARTRQ_ASSERT_NOW(a_stall_held, aclk, aresetn, !s_tready,
        in_valid_reg && out_valid_reg && !m_tready, "input stalled without a full pipeline")

endmodule

`default_nettype wire
